// ===== rtl/fasta_base_content_counter_top_macros.svh =====
// Assertion macros shared by the counter's RTL files.
`ifndef FASTA_BASE_CONTENT_COUNTER_TOP_MACROS_SVH
`define FASTA_BASE_CONTENT_COUNTER_TOP_MACROS_SVH

// Checked only while reset is low.
`define FBCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FBCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fbcc_pkg.sv =====
// Shared types, codes and helpers of the FASTA base-content counter.
package fbcc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [19:0] SEQ_MAX = 20'hFFFFF;

  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_GT = 8'h3E;
  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_C  = 8'h43;
  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  localparam logic [2:0] MODE_MOTIF     = 3'd0;
  localparam logic [2:0] MODE_GC_TOTAL  = 3'd1;
  localparam logic [2:0] MODE_CASE_TOT  = 3'd2;
  localparam logic [2:0] MODE_GC_WIN    = 3'd3;
  localparam logic [2:0] MODE_CASE_WIN  = 3'd4;

  localparam logic [1:0] KIND_MOTIF   = 2'd0;
  localparam logic [1:0] KIND_TOTALS  = 2'd1;
  localparam logic [1:0] KIND_WINDOW  = 2'd2;

  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_HDR  = 2'd1;
  localparam logic [1:0] OP_EOS  = 2'd2;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_WINDOW    = 3'd1;
  localparam logic [2:0] REG_PAT_LEN   = 3'd2;
  localparam logic [2:0] REG_PAT_LOW   = 3'd3;
  localparam logic [2:0] REG_PAT_HIGH  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] window_size;
    logic [4:0]  pattern_length;
    logic [63:0] pattern_chars_low;
    logic [63:0] pattern_chars_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       inc_one;
    logic       inc_two;
  } qent_t;

  typedef struct packed {
    logic [31:0] second_count;
    logic [31:0] first_count;
    logic [32:0] range_end;
    logic [31:0] range_start;
    logic [19:0] sequence_number;
    logic [1:0]  record_kind;
  } rec_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/fasta_base_content_counter_top.sv =====
// Top level of the FASTA base-content and motif counter.
// The slave stream carries one FASTA byte per beat in s_axis_tdata; a beat with
// s_axis_tlast high marks end of input, and its data byte is ignored.
// The master stream carries one count record per beat: the motif total, the
// per-sequence GC or case totals, or one window's counts, as set by mode.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce;
// a write takes effect with the next byte. A byte passes the parser in the
// cycle it is accepted and is written into a two-beat queue; the counting stage
// pops it once no stalled record holds it back and loads any record it causes
// into the output register, from which the master side presents it.
// Throughput is one byte per cycle while no record is stalled, set by the single
// counter update that the back end makes per queued entry.
// Reset clears the parser, the queue, all counters and the record valid flag,
// and sets the registers to their reset values.
// While the receiver stalls, the held record blocks the counting stage, the
// queue fills, and s_axis_tready falls until the record is taken.
module fasta_base_content_counter_top #(
  parameter int QUEUE_DEPTH = fbcc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] record_kind, [21:2] sequence_number, [53:22] range_start,
  // [86:54] range_end, [118:87] first_count, [150:119] second_count, [151] zero
  output logic [151:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import fbcc_pkg::*;

  cfg_t  cfg;
  qent_t front_ent;
  qent_t q_head;
  rec_t  rec;
  logic  front_push;
  logic  q_not_full;
  logic  q_not_empty;
  logic  back_pop;
  logic  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_MOTIF;
      cfg.window_size <= 32'd1;
      cfg.pattern_length <= 5'd1;
      cfg.pattern_chars_low <= '0;
      cfg.pattern_chars_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     cfg.mode <= cfg_data[2:0];
        REG_WINDOW:   cfg.window_size <= cfg_data[31:0];
        REG_PAT_LEN:  cfg.pattern_length <= cfg_data[4:0];
        REG_PAT_LOW:  cfg.pattern_chars_low <= cfg_data;
        REG_PAT_HIGH: cfg.pattern_chars_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = q_not_full;
  assign accept = s_axis_tvalid && s_axis_tready;

  fbcc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .char_code     (s_axis_tdata),
    .end_of_stream (s_axis_tlast),
    .push          (front_push),
    .ent           (front_ent)
  );

  fbcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_ent  (front_ent),
    .not_full  (q_not_full),
    .pop       (back_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  fbcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_ent     (q_head),
    .pop       (back_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (rec)
  );

  assign m_axis_tdata = {1'b0, rec};

endmodule

// ===== rtl/fbcc_front.sv =====
// Front end: line and header parsing and per-byte classification.
module fbcc_front (
  input  logic          clk,
  input  logic          rst,
  input  fbcc_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [7:0]    char_code,
  input  logic          end_of_stream,
  output logic          push,
  output fbcc_pkg::qent_t ent
);
  import fbcc_pkg::*;

  logic at_line_start, at_line_start_next;
  logic in_header, in_header_next;
  logic [7:0] up;
  logic is_lower_acgtn, is_upper_acgtn;

  assign up = upcase(char_code);
  assign is_lower_acgtn = (char_code == 8'h61) || (char_code == 8'h63) ||
                          (char_code == 8'h67) || (char_code == 8'h74) ||
                          (char_code == 8'h6E);
  assign is_upper_acgtn = (char_code == CHAR_A) || (char_code == CHAR_C) ||
                          (char_code == CHAR_G) || (char_code == CHAR_T) ||
                          (char_code == CHAR_N);

  always_comb begin
    ent.ch = up;
    ent.op = OP_CHAR;
    ent.inc_one = 1'b0;
    ent.inc_two = 1'b0;
    case (cfg.mode)
      MODE_GC_TOTAL, MODE_GC_WIN: begin
        ent.inc_two = (up == CHAR_G) || (up == CHAR_C);
        ent.inc_one = (up == CHAR_A) || (up == CHAR_T);
      end
      MODE_CASE_TOT: begin
        ent.inc_two = is_lower_acgtn;
        ent.inc_one = is_upper_acgtn;
      end
      MODE_CASE_WIN: begin
        ent.inc_two = (char_code >= 8'h61) && (char_code <= 8'h7A);
        ent.inc_one = (char_code >= 8'h41) && (char_code <= 8'h5A);
      end
      default: begin
        ent.inc_one = 1'b0;
        ent.inc_two = 1'b0;
      end
    endcase

    push = 1'b0;
    at_line_start_next = at_line_start;
    in_header_next = in_header;
    if (accept) begin
      if (end_of_stream) begin
        push = 1'b1;
        ent.op = OP_EOS;
        at_line_start_next = 1'b1;
        in_header_next = 1'b0;
      end else if (in_header) begin
        if (char_code == CHAR_NL) begin
          in_header_next = 1'b0;
          at_line_start_next = 1'b1;
        end
      end else if (char_code == CHAR_NL) begin
        at_line_start_next = 1'b1;
      end else if (at_line_start && char_code == CHAR_GT) begin
        push = 1'b1;
        ent.op = OP_HDR;
        at_line_start_next = 1'b0;
        in_header_next = 1'b1;
      end else begin
        at_line_start_next = 1'b0;
        push = (cfg.mode <= MODE_CASE_WIN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      in_header <= 1'b0;
    end else begin
      at_line_start <= at_line_start_next;
      in_header <= in_header_next;
    end
  end

endmodule

// ===== rtl/fbcc_queue.sv =====
// Short queue between the parsing front end and the counting back end.
module fbcc_queue #(
  parameter int DEPTH = fbcc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fbcc_pkg::qent_t push_ent,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output fbcc_pkg::qent_t head
);
  import fbcc_pkg::*;
  `include "fasta_base_content_counter_top_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  qent_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full = (count != FULL);
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `FBCC_ASSERT(q_no_overflow, push |-> (not_full || pop), "queue push while full")
  `FBCC_ASSERT(q_no_underflow, pop |-> not_empty, "queue pop while empty")
  `FBCC_ASSERT_ALWAYS(q_count_bound, rst || (count <= FULL), "queue count beyond depth")

endmodule

// ===== rtl/fbcc_back.sv =====
// Back end: motif matching, content counters, windows and the record register.
module fbcc_back (
  input  logic            clk,
  input  logic            rst,
  input  fbcc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  fbcc_pkg::qent_t q_ent,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output fbcc_pkg::rec_t  out_rec
);
  import fbcc_pkg::*;
  `include "fasta_base_content_counter_top_macros.svh"

  logic        record_open, record_open_next;
  logic        header_seen, header_seen_next;
  logic [31:0] position, position_next;
  logic [31:0] window_offset, window_offset_next;
  logic [31:0] window_begin, window_begin_next;
  logic [31:0] count_one, count_one_next;
  logic [31:0] count_two, count_two_next;
  logic [4:0]  match_index, match_index_next;
  logic [19:0] sequence_counter, sequence_counter_next;

  logic        valid_mode;
  logic        windowed;
  logic        emit;
  logic [4:0]  len;
  logic [127:0] pat;
  logic [7:0]  pch;
  logic        hit;
  logic [4:0]  mi_step;
  logic [31:0] c1_base, c2_base;
  logic [31:0] off_inc;
  rec_t        rec;

  assign valid_mode = (cfg.mode <= MODE_CASE_WIN);
  assign windowed = (cfg.mode == MODE_GC_WIN) || (cfg.mode == MODE_CASE_WIN);
  assign pop = q_valid && (!out_valid || out_ready);
  assign len = (cfg.pattern_length == 5'd0) ? 5'd1 :
               (cfg.pattern_length > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) :
               cfg.pattern_length;
  assign pat = {cfg.pattern_chars_high, cfg.pattern_chars_low};
  assign pch = pat[{match_index[3:0], 3'b000} +: 8];
  assign hit = (match_index < len) && ((q_ent.ch == upcase(pch)) || (pch == CHAR_N));
  assign mi_step = hit ? match_index + 5'd1 : 5'd0;
  assign off_inc = window_offset + 32'd1;

  always_comb begin
    rec.record_kind = (cfg.mode == MODE_MOTIF) ? KIND_MOTIF :
                      (cfg.mode <= MODE_CASE_TOT) ? KIND_TOTALS : KIND_WINDOW;
    rec.sequence_number = sequence_counter;
    rec.range_start = (rec.record_kind == KIND_WINDOW) ? window_begin : 32'd0;
    rec.range_end = {1'b0, position} - 33'd1;
    rec.first_count = count_one;
    rec.second_count = (rec.record_kind == KIND_MOTIF) ? 32'd0 : count_two;
  end

  always_comb begin
    record_open_next = record_open;
    header_seen_next = header_seen;
    position_next = position;
    window_offset_next = window_offset;
    window_begin_next = window_begin;
    count_one_next = count_one;
    count_two_next = count_two;
    match_index_next = match_index;
    sequence_counter_next = sequence_counter;
    c1_base = count_one;
    c2_base = count_two;
    emit = 1'b0;
    if (pop) begin
      case (q_ent.op)
        OP_EOS: begin
          emit = valid_mode;
          record_open_next = 1'b0;
          header_seen_next = 1'b0;
          sequence_counter_next = '0;
          position_next = '0;
          window_offset_next = '0;
          window_begin_next = '0;
          count_one_next = '0;
          count_two_next = '0;
          match_index_next = '0;
        end
        OP_HDR: begin
          emit = valid_mode && record_open;
          position_next = '0;
          window_offset_next = '0;
          window_begin_next = '0;
          count_one_next = '0;
          count_two_next = '0;
          match_index_next = '0;
          record_open_next = valid_mode && (cfg.mode <= MODE_CASE_TOT);
          if (header_seen && sequence_counter != SEQ_MAX) begin
            sequence_counter_next = sequence_counter + 20'd1;
          end
          header_seen_next = 1'b1;
        end
        OP_CHAR: begin
          if (valid_mode) begin
            if (windowed) begin
              if (window_offset == 32'd0) begin
                emit = record_open;
                c1_base = '0;
                c2_base = '0;
                window_begin_next = position;
              end
              record_open_next = 1'b1;
              window_offset_next = (off_inc == cfg.window_size) ? 32'd0 : off_inc;
            end
            count_one_next = c1_base;
            count_two_next = c2_base;
            if (cfg.mode == MODE_MOTIF) begin
              if (mi_step >= len) begin
                match_index_next = '0;
                count_one_next = sat_inc(c1_base);
              end else begin
                match_index_next = mi_step;
              end
            end else begin
              if (q_ent.inc_one) begin
                count_one_next = sat_inc(c1_base);
              end
              if (q_ent.inc_two) begin
                count_two_next = sat_inc(c2_base);
              end
            end
            position_next = position + 32'd1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_open <= 1'b0;
      header_seen <= 1'b0;
      position <= '0;
      window_offset <= '0;
      window_begin <= '0;
      count_one <= '0;
      count_two <= '0;
      match_index <= '0;
      sequence_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      record_open <= record_open_next;
      header_seen <= header_seen_next;
      position <= position_next;
      window_offset <= window_offset_next;
      window_begin <= window_begin_next;
      count_one <= count_one_next;
      count_two <= count_two_next;
      match_index <= match_index_next;
      sequence_counter <= sequence_counter_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_rec <= rec;
    end
  end

  `FBCC_ASSERT(b_eos_closes, (pop && q_ent.op == OP_EOS) |=> (!record_open && !header_seen),
               "end of stream left a record open")
  `FBCC_ASSERT(b_match_bound, match_index < 5'(MAX_PATTERN), "match index out of range")
  `FBCC_ASSERT(b_no_overwrite, (out_valid && !out_ready) |-> !pop,
               "back end advanced while a record was stalled")

endmodule

// ===== tb/sv/base_count_checker.sv =====
// Predicts the count records of the FASTA base-content counter and checks each record beat.
module base_count_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] record_kind, [21:2] sequence_number, [53:22] range_start,
  // [86:54] range_end, [118:87] first_count, [150:119] second_count, [151] zero
  input  logic [151:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           mismatches,
  output int           records_owed
);
  import fbcc_pkg::*;

  logic [2:0]  cfg_mode;
  logic [31:0] cfg_window;
  logic [4:0]  cfg_pat_len;
  logic [63:0] cfg_pat_low;
  logic [63:0] cfg_pat_high;

  logic        line_start;
  logic        in_header;
  logic        record_open;
  logic        header_seen;
  logic [31:0] char_pos;
  logic [31:0] win_offset;
  logic [31:0] win_first;
  logic [31:0] tally_one;
  logic [31:0] tally_two;
  logic [4:0]  motif_idx;
  logic [19:0] seq_index;

  rec_t owed_records[$];
  int   errors = 0;

  initial begin
    mismatches = 0;
    records_owed = 0;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [31:0] bump_count(input logic [31:0] v);
    return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
  endfunction

  task automatic clear_sequence();
    char_pos = '0;
    win_offset = '0;
    win_first = '0;
    tally_one = '0;
    tally_two = '0;
    motif_idx = '0;
  endtask

  task automatic clear_stream();
    line_start = 1'b1;
    in_header = 1'b0;
    record_open = 1'b0;
    header_seen = 1'b0;
    seq_index = '0;
    clear_sequence();
  endtask

  task automatic queue_record();
    rec_t r;
    if (cfg_mode == MODE_MOTIF) begin
      r.record_kind = KIND_MOTIF;
    end else if (cfg_mode <= MODE_CASE_TOT) begin
      r.record_kind = KIND_TOTALS;
    end else begin
      r.record_kind = KIND_WINDOW;
    end
    r.sequence_number = seq_index;
    r.range_start = (r.record_kind == KIND_WINDOW) ? win_first : 32'd0;
    r.range_end = {1'b0, char_pos} - 33'd1;
    r.first_count = tally_one;
    r.second_count = (r.record_kind == KIND_MOTIF) ? 32'd0 : tally_two;
    owed_records.push_back(r);
  endtask

  task automatic tally_char(input logic [7:0] ch);
    logic [4:0]  plen;
    logic [63:0] word;
    logic [7:0]  pc;
    logic [7:0]  up;
    up = fold_case(ch);
    case (cfg_mode)
      MODE_MOTIF: begin
        plen = cfg_pat_len;
        if (plen == 5'd0) plen = 5'd1;
        if (plen > MAX_PATTERN) plen = 5'(MAX_PATTERN);
        word = motif_idx[3] ? cfg_pat_high : cfg_pat_low;
        pc = word[motif_idx[2:0] * 8 +: 8];
        if (motif_idx < plen && (up == fold_case(pc) || pc == CHAR_N)) begin
          motif_idx = motif_idx + 5'd1;
        end else begin
          motif_idx = '0;
        end
        if (motif_idx >= plen) begin
          motif_idx = '0;
          tally_one = bump_count(tally_one);
        end
      end
      MODE_GC_TOTAL, MODE_GC_WIN: begin
        if (up == CHAR_G || up == CHAR_C) begin
          tally_two = bump_count(tally_two);
        end else if (up == CHAR_A || up == CHAR_T) begin
          tally_one = bump_count(tally_one);
        end
      end
      MODE_CASE_TOT: begin
        if (up == CHAR_A || up == CHAR_C || up == CHAR_G || up == CHAR_T || up == CHAR_N) begin
          if (up == ch) begin
            tally_one = bump_count(tally_one);
          end else begin
            tally_two = bump_count(tally_two);
          end
        end
      end
      default: begin
        if (ch >= "a" && ch <= "z") begin
          tally_two = bump_count(tally_two);
        end else if (ch >= "A" && ch <= "Z") begin
          tally_one = bump_count(tally_one);
        end
      end
    endcase
  endtask

  task automatic absorb_byte(input logic [7:0] ch, input logic eos);
    logic active;
    active = (cfg_mode <= MODE_CASE_WIN);
    if (eos) begin
      if (active) queue_record();
      clear_stream();
    end else if (in_header) begin
      if (ch == CHAR_NL) begin
        in_header = 1'b0;
        line_start = 1'b1;
      end
    end else if (ch == CHAR_NL) begin
      line_start = 1'b1;
    end else if (line_start && ch == CHAR_GT) begin
      line_start = 1'b0;
      in_header = 1'b1;
      if (active && record_open) queue_record();
      clear_sequence();
      record_open = active && cfg_mode <= MODE_CASE_TOT;
      if (header_seen && seq_index != SEQ_MAX) seq_index = seq_index + 20'd1;
      header_seen = 1'b1;
    end else begin
      line_start = 1'b0;
      if (active) begin
        if (cfg_mode >= MODE_GC_WIN) begin
          if (win_offset == 32'd0) begin
            if (record_open) queue_record();
            tally_one = '0;
            tally_two = '0;
            win_first = char_pos;
          end
          record_open = 1'b1;
          tally_char(ch);
          win_offset = win_offset + 32'd1;
          if (win_offset == cfg_window) win_offset = '0;
        end else begin
          tally_char(ch);
        end
        char_pos = char_pos + 32'd1;
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [32:0] want,
                               input logic [32:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 100) $error("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    rec_t want;
    rec_t got;
    if (rst) begin
      cfg_mode = MODE_MOTIF;
      cfg_window = 32'd1;
      cfg_pat_len = 5'd1;
      cfg_pat_low = '0;
      cfg_pat_high = '0;
      clear_stream();
      owed_records.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     cfg_mode = cfg_data[2:0];
          REG_WINDOW:   cfg_window = cfg_data[31:0];
          REG_PAT_LEN:  cfg_pat_len = cfg_data[4:0];
          REG_PAT_LOW:  cfg_pat_low = cfg_data;
          REG_PAT_HIGH: cfg_pat_high = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_records.size() == 0) begin
          errors++;
          if (errors <= 100) $error("record beat arrived with no record expected");
        end else begin
          want = owed_records.pop_front();
          got = m_axis_tdata[150:0];
          compare_field("record_kind", 33'(want.record_kind), 33'(got.record_kind));
          compare_field("sequence_number", 33'(want.sequence_number),
                        33'(got.sequence_number));
          compare_field("range_start", 33'(want.range_start), 33'(got.range_start));
          compare_field("range_end", want.range_end, got.range_end);
          compare_field("first_count", 33'(want.first_count), 33'(got.first_count));
          compare_field("second_count", 33'(want.second_count), 33'(got.second_count));
          compare_field("padding", 33'd0, 33'(m_axis_tdata[151]));
        end
      end
    end
    mismatches <= errors;
    records_owed <= owed_records.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the counter testbench: clock, reset, FASTA stimulus, receiver stalls and verdict.
module testbench;
  import fbcc_pkg::*;

  localparam logic [2:0] MODE_SPARE_LOW  = 3'd5;
  localparam logic [2:0] MODE_SPARE_HIGH = 3'd7;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] char_code
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [1:0] record_kind, [21:2] sequence_number, [53:22] range_start,
  // [86:54] range_end, [118:87] first_count, [150:119] second_count, [151] zero
  logic [151:0] m_axis_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;
  int           mismatches;
  int           records_owed;

  int           burst_left = 0;
  int           beats_sent = 0;
  int           stall_left = 0;
  rx_style_t    stall_style = RX_OPEN;
  logic [2:0]   cur_mode;
  logic [4:0]   cur_pat_len;
  logic [127:0] cur_pat;

  fasta_base_content_counter_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  base_count_checker record_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .records_owed(records_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = rx_style_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_style)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= ((stall_left % 12) < 3);
    endcase
  end

  function automatic logic [7:0] base_byte();
    string alphabet = "ACGTNacgtnACGTacgt";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(65, 122));
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] pattern_byte();
    string alphabet = "ACGTNNacgtn";
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input logic [7:0] ch, input logic eos);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= eos;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Stops the sender and lets the block drain before registers change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (records_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_fasta(input int beats);
    int target;
    int n;
    int span;
    logic [7:0] b;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          send_beat(CHAR_GT, 1'b0);
          repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_NL) b = CHAR_GT;
            send_beat(b, 1'b0);
          end
          send_beat(CHAR_NL, 1'b0);
        end
        15, 16: begin
          span = (cur_pat_len == 5'd0) ? 1 : (cur_pat_len > MAX_PATTERN) ? MAX_PATTERN
                                                                          : cur_pat_len;
          for (int i = 0; i < span; i++) begin
            b = cur_pat[8 * i +: 8];
            if (b == CHAR_N || $urandom_range(0, 15) == 0) b = base_byte();
            send_beat(b, 1'b0);
          end
        end
        17, 18: begin
          repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        19: begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        default: begin
          n = $urandom_range(0, 16);
          repeat (n) send_beat(base_byte(), 1'b0);
          if ($urandom_range(0, 4) == 0) send_beat(CHAR_CR, 1'b0);
          send_beat(CHAR_NL, 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_MODE, 64'(MODE_CASE_WIN));
    write_reg(REG_WINDOW, 64'd3);
    send_text("Ac>\n>s1\nacgtNn\015");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("\n>\nGT");
    send_beat(8'($urandom_range(0, 255)), 1'b1);

    for (int p = 0; p < 16; p++) begin
      settle();
      case (p % 5)
        0: cur_mode = MODE_MOTIF;
        1: cur_mode = MODE_GC_TOTAL;
        2: cur_mode = MODE_CASE_TOT;
        3: cur_mode = MODE_GC_WIN;
        default: cur_mode = MODE_CASE_WIN;
      endcase
      if (p == 14) cur_mode = MODE_SPARE_LOW;
      if (p == 15) cur_mode = MODE_SPARE_HIGH;
      for (int i = 0; i < 16; i++) cur_pat[8 * i +: 8] = pattern_byte();
      if (p == 15) cur_pat = {64'd0, 64'hFFFFFFFFFFFFFFFF};
      cur_pat_len = 5'($urandom_range(1, 6));
      if (p == 0) cur_pat_len = 5'd0;
      if (p == 5) cur_pat_len = 5'(MAX_PATTERN);
      if (p == 10) cur_pat_len = 5'd31;
      write_reg(REG_MODE, 64'(cur_mode));
      case (p)
        3: write_reg(REG_WINDOW, 64'd1);
        4: write_reg(REG_WINDOW, 64'd0);
        8: write_reg(REG_WINDOW, 64'hFFFFFFFF);
        9: write_reg(REG_WINDOW, 64'd2);
        default: write_reg(REG_WINDOW, 64'($urandom_range(1, 12)));
      endcase
      write_reg(REG_PAT_LEN, 64'(cur_pat_len));
      write_reg(REG_PAT_LOW, cur_pat[63:0]);
      write_reg(REG_PAT_HIGH, cur_pat[127:64]);
      send_fasta((p >= 14) ? 20 : 54);
      if ($urandom_range(0, 3) != 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    settle();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && records_owed == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fbcc_pkg.sv
rtl/fbcc_front.sv
rtl/fbcc_queue.sv
rtl/fbcc_back.sv
rtl/fasta_base_content_counter_top.sv
tb/sv/base_count_checker.sv
tb/sv/testbench.sv
